FILE: sv/idle_page_age_histogram_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the idle page age histogram back end (ipah_back)
// ----------------------------------------------------------------------------
`ifndef IDLE_PAGE_AGE_HISTOGRAM_CORE_MACROS_SVH
`define IDLE_PAGE_AGE_HISTOGRAM_CORE_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define IPAH_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ipah assertion failed");

// Antecedent implies consequent in the next cycle.
`define IPAH_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ipah assertion failed");

`endif

FILE: sv/ipah_pkg.sv
// ----------------------------------------------------------------------------
// ipah_pkg
// Types and constants of the idle page age histogram core.
// ----------------------------------------------------------------------------
`default_nettype none
package ipah_pkg;

   localparam int NUM_EDGES = 8;
   localparam logic [3:0] ORDER_LIMIT = 4'd9;

   typedef logic [NUM_EDGES-1:0][7:0] edge_array_type;

   localparam edge_array_type EDGE_RESET =
      {8'd240, 8'd120, 8'd60, 8'd30, 8'd15, 8'd5, 8'd2, 8'd1};

   typedef enum logic [1:0] {
      OP_SCAN = 2'd0,
      OP_EOR  = 2'd1,
      OP_READ = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_AGE,
      ST_HIST,
      ST_READ
   } state_type;

   // One classified word handed from front to back.
   typedef struct packed {
      op_type      op;
      logic [11:0] idx;
      logic        in_range;
      logic        valid;
      logic        lru;
      logic        idle;
      logic        pinned;
      logic        still;
      logic [3:0]  order;
      logic [3:0]  rtype;
      logic [2:0]  col;
   } item_type;

endpackage
`default_nettype wire

FILE: sv/idle_page_age_histogram_core.sv
// Idle page age histogram core. Each request word is a page scan, an end of
// round, a histogram read or a no-op, and each yields exactly one response
// word. After reset the block sweeps the age store to zero, one page per
// cycle (at most 4096 pages), and holds req_tready low meanwhile; bucket
// edges may be written at any time while idle. A scan whose page is counted
// steps through the age store read, the decision and the histogram
// read-modify-write, and skips the last step otherwise; a read steps through
// the histogram read and the response; an end of round responds from idle.
// A two-word queue between the request side and the executing back end, and
// a response register, let either side stall without stopping the other.
// ----------------------------------------------------------------------------
// idle_page_age_histogram_core
// Top level: bucket edge registers, request front end and execution back end.
// ----------------------------------------------------------------------------
`default_nettype none
module idle_page_age_histogram_core #(
   parameter int PAGE_COUNT   = 4096,
   parameter int BUCKET_COUNT = 8,
   parameter int AGE_MAX      = 255,
   parameter int COUNT_BITS   = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // page_index[11:0], page_valid, on_lru, idle_flag, pinned_ok, still_idle,
   // page_order[3:0], type_flags[3:0], bucket_index[2:0], zero pad
   input  wire logic [31:0] req_tdata,
   // operation[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // pages_advanced[9:0], page_age[7:0], page_was_idle, mark_idle,
   // count_value[31:0], zero pad
   output logic [55:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);
   import ipah_pkg::*;

   edge_array_type edges_ff;
   item_type       q_item;
   logic           q_valid, pop, clearing;

   // hold bucket edges; write one per enabled cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         edges_ff <= EDGE_RESET;
      end else if (csr_we) begin
         edges_ff[csr_index] <= csr_wdata;
      end
   end

   ipah_front #(.PAGE_COUNT(PAGE_COUNT)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .clearing   (clearing),
      .pop        (pop),
      .q_valid    (q_valid),
      .q_item     (q_item)
   );

   ipah_back #(
      .PAGE_COUNT   (PAGE_COUNT),
      .BUCKET_COUNT (BUCKET_COUNT),
      .AGE_MAX      (AGE_MAX),
      .COUNT_BITS   (COUNT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .edges      (edges_ff),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

FILE: sv/ipah_front.sv
// ----------------------------------------------------------------------------
// ipah_front
// Accept request words, classify them and queue them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module ipah_front #(
   parameter int PAGE_COUNT = 4096
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [31:0]      req_tdata,
   input  wire logic [1:0]       req_tuser,
   input  wire logic             clearing,
   input  wire logic             pop,
   output logic                  q_valid,
   output ipah_pkg::item_type    q_item
);
   import ipah_pkg::*;

   item_type   fifo_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   cls;
   logic       push;

   always_comb begin
      cls.op       = op_type'(req_tuser);
      cls.idx      = req_tdata[11:0];
      cls.in_range = (32'(req_tdata[11:0]) < 32'(PAGE_COUNT));
      cls.valid    = req_tdata[12];
      cls.lru      = req_tdata[13];
      cls.idle     = req_tdata[14];
      cls.pinned   = req_tdata[15];
      cls.still    = req_tdata[16];
      // clamp order to the largest compound size
      cls.order    = (req_tdata[20:17] > ORDER_LIMIT) ? ORDER_LIMIT : req_tdata[20:17];
      cls.rtype    = req_tdata[24:21];
      cls.col      = req_tdata[27:25];
   end

   assign req_tready = (count_ff != 2'd2) && !clearing;
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign q_item     = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule
`default_nettype wire

FILE: sv/ipah_back.sv
// ----------------------------------------------------------------------------
// ipah_back
// Execute queued words against the age store and histogram banks.
// ----------------------------------------------------------------------------
`default_nettype none
`include "idle_page_age_histogram_core_macros.svh"
module ipah_back #(
   parameter int PAGE_COUNT   = 4096,
   parameter int BUCKET_COUNT = 8,
   parameter int AGE_MAX      = 255,
   parameter int COUNT_BITS   = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ipah_pkg::edge_array_type edges,
   input  wire logic                    q_valid,
   input  wire ipah_pkg::item_type      q_item,
   output logic                         pop,
   output logic                         clearing,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [55:0]                  rsp_tdata
);
   import ipah_pkg::*;

   localparam int AGE_DEPTH = (PAGE_COUNT < 4096) ? PAGE_COUNT : 4096;
   localparam int AGE_AW    = $clog2(AGE_DEPTH);
   localparam logic [7:0] AGE_TOP = 8'(AGE_MAX);
   localparam logic [AGE_AW-1:0] CLR_LAST = AGE_AW'(AGE_DEPTH - 1);

   logic [7:0]            age_mem [AGE_DEPTH];
   logic [COUNT_BITS-1:0] hist_mem [256];
   logic [255:0]          hv_ff;

   state_type             state_ff, state_in;
   item_type              cur_ff;
   logic [AGE_AW-1:0]     clr_ff, clr_in;
   logic                  bank_ff;
   logic [2:0]            round_ff;
   logic [7:0]            age_rd_ff;
   logic [COUNT_BITS-1:0] hist_rd_ff;
   logic                  hv_rd_ff;
   logic [7:0]            hist_addr_ff;

   logic                  rsp_valid_ff;
   logic [9:0]            pages_ff, pages_in;
   logic [7:0]            age_out_ff, age_out_in;
   logic                  was_idle_ff, was_idle_in;
   logic                  mark_ff, mark_in;
   logic [31:0]           count_ff, count_in;

   logic                  out_free, rsp_load, eor;
   logic                  age_re, age_we, hist_re, hist_we;
   logic [AGE_AW-1:0]     age_ra, age_wa;
   logic [7:0]            age_wd;
   logic [7:0]            hist_ra;
   logic [COUNT_BITS-1:0] hist_wd;

   logic [11:0]           shifted;
   logic [2:0]            samp_s;
   logic                  sampled, idle, found, account;
   logic [7:0]            new_age;
   logic [2:0]            bkt;
   logic [COUNT_BITS:0]   sum;
   logic [COUNT_BITS-1:0] cur_cnt;
   logic [COUNT_BITS+31:0] cnt_ext;

   function automatic logic [9:0] pages_ff_pages(input logic [3:0] ord);
      pages_ff_pages = 10'd1 << ord;
   endfunction

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign clearing = (state_ff == ST_CLEAR);

   // scan decision from the registered age
   always_comb begin
      shifted = cur_ff.idx >> cur_ff.order;
      samp_s  = shifted[2:0] + round_ff;
      if (age_rd_ff == 8'd0)       sampled = samp_s[0];
      else if (age_rd_ff < 8'd4)   sampled = 1'b1;
      else if (age_rd_ff < 8'd8)   sampled = samp_s[0];
      else if (age_rd_ff < 8'd16)  sampled = (samp_s[1:0] == 2'd3);
      else                         sampled = (samp_s == 3'd7);
      idle    = cur_ff.idle && (sampled ? cur_ff.still : (age_rd_ff != 8'd0));
      new_age = (age_rd_ff < AGE_TOP) ? age_rd_ff + 8'd1 : age_rd_ff;
      found   = 1'b0;
      bkt     = 3'(BUCKET_COUNT - 1);
      for (int k = 1; k < NUM_EDGES; k++) begin
         if (k < BUCKET_COUNT && !found && new_age < edges[k]) begin
            bkt   = 3'(k - 1);
            found = 1'b1;
         end
      end
      account = idle && (new_age >= edges[0]);
   end

   // saturating histogram add; invalid entries read as zero
   always_comb begin
      cur_cnt = hv_rd_ff ? hist_rd_ff : '0;
      sum     = {1'b0, cur_cnt} + (COUNT_BITS+1)'(pages_ff_pages(cur_ff.order));
      hist_wd = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
      cnt_ext = {32'b0, cur_cnt};
   end

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      pop         = 1'b0;
      eor         = 1'b0;
      rsp_load    = 1'b0;
      age_re      = 1'b0;
      age_ra      = q_item.idx[AGE_AW-1:0];
      age_we      = 1'b0;
      age_wa      = cur_ff.idx[AGE_AW-1:0];
      age_wd      = 8'd0;
      hist_re     = 1'b0;
      hist_ra     = {bank_ff, cur_ff.rtype, bkt};
      hist_we     = 1'b0;
      pages_in    = 10'd0;
      age_out_in  = 8'd0;
      was_idle_in = 1'b0;
      mark_in     = 1'b0;
      count_in    = 32'd0;
      case (state_ff)
         ST_CLEAR: begin
            age_we = 1'b1;
            age_wa = clr_ff;
            clr_in = clr_ff + AGE_AW'(1);
            if (clr_ff == CLR_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (q_valid && out_free) begin
               pop = 1'b1;
               case (q_item.op)
                  OP_SCAN: begin
                     age_re   = 1'b1;
                     state_in = ST_AGE;
                  end
                  OP_EOR: begin
                     eor      = 1'b1;
                     rsp_load = 1'b1;
                  end
                  OP_READ: begin
                     hist_re  = 1'b1;
                     hist_ra  = {~bank_ff, q_item.rtype, q_item.col};
                     state_in = ST_READ;
                  end
                  default: rsp_load = 1'b1;
               endcase
            end
         end
         ST_AGE: begin
            rsp_load = 1'b1;
            pages_in = 10'd1;
            state_in = ST_IDLE;
            if (!cur_ff.in_range) begin
               age_out_in = 8'd0;
            end else if (!cur_ff.valid) begin
               age_out_in = age_rd_ff;
            end else if (!cur_ff.lru || (cur_ff.idle && sampled && !cur_ff.pinned)) begin
               age_we = 1'b1;
            end else begin
               pages_in = pages_ff_pages(cur_ff.order);
               age_we   = 1'b1;
               if (idle) begin
                  age_wd      = new_age;
                  age_out_in  = new_age;
                  was_idle_in = 1'b1;
                  if (account) begin
                     hist_re  = 1'b1;
                     state_in = ST_HIST;
                  end
               end else begin
                  mark_in = cur_ff.pinned;
               end
            end
         end
         ST_HIST: begin
            hist_we  = 1'b1;
            state_in = ST_IDLE;
         end
         ST_READ: begin
            rsp_load = 1'b1;
            if ({1'b0, cur_ff.col} < 4'(BUCKET_COUNT)) count_in = cnt_ext[31:0];
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         bank_ff      <= 1'b0;
         round_ff     <= 3'd0;
         hv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (eor) begin
            bank_ff  <= ~bank_ff;
            round_ff <= round_ff + 3'd1;
            // drop every count of the bank that becomes the working one
            for (int i = 0; i < 256; i++) begin
               if (i[7] == ~bank_ff) hv_ff[i] <= 1'b0;
            end
         end
         if (hist_we) hv_ff[hist_addr_ff] <= 1'b1;
         if (rsp_load)        rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) cur_ff <= q_item;
      if (rsp_load) begin
         pages_ff    <= pages_in;
         age_out_ff  <= age_out_in;
         was_idle_ff <= was_idle_in;
         mark_ff     <= mark_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (age_re) age_rd_ff <= age_mem[age_ra];
      if (age_we) age_mem[age_wa] <= age_wd;
   end

   always_ff @(posedge clock) begin
      if (hist_re) begin
         hist_rd_ff   <= hist_mem[hist_ra];
         hv_rd_ff     <= hv_ff[hist_ra];
         hist_addr_ff <= hist_ra;
      end
      if (hist_we) hist_mem[hist_addr_ff] <= hist_wd;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, count_ff, mark_ff, was_idle_ff, age_out_ff, pages_ff};

   `IPAH_ASSERT_NOW(a_age_out_free, state_ff == ST_AGE, !rsp_valid_ff)
   `IPAH_ASSERT_NOW(a_no_pop_clear, state_ff == ST_CLEAR, !pop)
   `IPAH_ASSERT_NEXT(a_hist_done, state_ff == ST_HIST, state_ff == ST_IDLE)

endmodule
`default_nettype wire
